// ===== src/canopen_drive_status_receiver_assert.svh =====
// Assertion macros for the drive status receiver.
`ifndef CANOPEN_DRIVE_STATUS_RECEIVER_ASSERT_SVH
`define CANOPEN_DRIVE_STATUS_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CDSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CDSR_ASSERT_NEVER(lbl, cond, msg) \
  `CDSR_ASSERT(lbl, !(cond), msg)
`else
`define CDSR_ASSERT(lbl, prop, msg)
`define CDSR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/cdsr_pkg.sv =====
// Types and constants shared by the drive status receiver modules.
package cdsr_pkg;

  localparam logic [15:0] OBJ_STATUS_WORD = 16'h6041;
  localparam logic [15:0] OBJ_ERROR_CODE  = 16'h603F;
  localparam logic [3:0]  BASE_EMCY  = 4'h1;
  localparam logic [3:0]  BASE_TPDO1 = 4'h3;
  localparam logic [3:0]  BASE_TPDO2 = 4'h5;
  localparam logic [3:0]  BASE_SDO   = 4'hB;
  localparam logic [7:0]  EMCY_COMM_HI = 8'h81;
  localparam logic [15:0] EMCY_COMM_FAULT = 16'h8130;
  localparam logic [7:0]  SDO_CMD_MASK = 8'hE0;
  localparam logic [7:0]  SDO_CMD_UPLOAD = 8'h40;

  localparam logic [1:0] MSG_NONE     = 2'd0;
  localparam logic [1:0] MSG_SW_FAULT = 2'd1;
  localparam logic [1:0] MSG_EMCY     = 2'd2;

  localparam int FL_READY    = 0;
  localparam int FL_SWITCHED = 1;
  localparam int FL_OPEN     = 2;
  localparam int FL_FAULT    = 3;
  localparam int FL_MOTOR    = 4;
  localparam int FL_VALID    = 5;

  localparam logic [3:0] FB_POS_VEL = 4'h9;
  localparam logic [3:0] FB_CURRENT = 4'hA;
  localparam logic [3:0] FB_DEMANDS = 4'h4;

  typedef enum logic [1:0] {
    RK_STATUS   = 2'd0,
    RK_FEEDBACK = 2'd1,
    RK_CURRENT  = 2'd2
  } report_kind_e;

  typedef enum logic [2:0] {
    FK_NONE  = 3'd0,
    FK_TPDO1 = 3'd1,
    FK_TPDO2 = 3'd2,
    FK_SW    = 3'd3,
    FK_ERR   = 3'd4,
    FK_EMCY  = 3'd5
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    logic        side;
    logic        full;
  } event_t;

  typedef struct packed {
    logic [15:0] sw;
    logic [15:0] err;
    logic [5:0]  flags;
    logic [1:0]  msg;
    logic        pend;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [15:0] cur;
    logic [31:0] vd;
    logic [15:0] cd;
    logic [3:0]  fb;
  } node_t;

  typedef struct packed {
    logic         emit;
    report_kind_e kind;
    logic         side;
    logic         req;
    node_t        node;
  } result_t;

endpackage

// ===== src/canopen_drive_status_receiver.sv =====
// Top level of the CANopen drive status receiver for two drives.
// One received CAN frame is taken per request into an input register, classified and
// applied to the state of the matching drive, and at most one report is placed in the
// output register. A report is registered when its frame leaves the input register, and
// a new frame is accepted every cycle while the output side keeps taking reports; the
// single input register and the single result register set that rate. Node ids are written
// over the APB port at addresses 0 and 4 and should be changed only while idle.
module canopen_drive_status_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [10:0]        can_id_i,
  input  logic [3:0]         frame_length_i,
  input  logic [7:0]         byte0_i,
  input  logic [7:0]         byte1_i,
  input  logic [7:0]         byte2_i,
  input  logic [7:0]         byte3_i,
  input  logic [7:0]         byte4_i,
  input  logic [7:0]         byte5_i,
  input  logic [7:0]         byte6_i,
  input  logic [7:0]         byte7_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         report_kind_o,
  output logic               side_o,
  output logic [15:0]        drive_status_word_o,
  output logic [15:0]        drive_error_code_o,
  output logic [7:0]         status_flags_o,
  output logic               request_error_read_o,
  output logic signed [31:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [15:0] current_o,
  output logic signed [31:0] velocity_setpoint_o,
  output logic signed [15:0] current_setpoint_o,
  output logic [3:0]         feedback_flags_o
);
  import cdsr_pkg::*;

  localparam logic REG_LEFT  = 1'b0;
  localparam logic REG_RIGHT = 1'b1;

  logic [6:0]  left_q, right_q;
  logic        in_valid_q;
  logic [10:0] can_id_q;
  logic [3:0]  len_q;
  logic [63:0] data_q;
  logic        advance;
  event_t      ev;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_LEFT:  prdata = {25'd0, left_q};
      REG_RIGHT: prdata = {25'd0, right_q};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= 7'd1;
      right_q <= 7'd2;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LEFT:  left_q  <= pwdata[6:0];
        REG_RIGHT: right_q <= pwdata[6:0];
        default:   left_q  <= left_q;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      can_id_q <= can_id_i;
      len_q    <= frame_length_i;
      data_q   <= {byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i, byte0_i};
    end
  end

  cdsr_decode u_decode (
    .can_id_i        (can_id_q),
    .frame_length_i  (len_q),
    .data_i          (data_q),
    .left_node_id_i  (left_q),
    .right_node_id_i (right_q),
    .event_o         (ev)
  );

  cdsr_nodes u_nodes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .event_i  (ev),
    .data_i   (data_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) out_q <= res;
  end

  assign out_valid_o          = out_valid_q;
  assign report_kind_o        = out_q.kind;
  assign side_o               = out_q.side;
  assign drive_status_word_o  = out_q.node.sw;
  assign drive_error_code_o   = out_q.node.err;
  assign status_flags_o       = {out_q.node.msg, out_q.node.flags};
  assign request_error_read_o = out_q.req;
  assign position_o           = $signed(out_q.node.pos);
  assign velocity_o           = $signed(out_q.node.vel);
  assign current_o            = $signed(out_q.node.cur);
  assign velocity_setpoint_o  = $signed(out_q.node.vd);
  assign current_setpoint_o   = $signed(out_q.node.cd);
  assign feedback_flags_o     = out_q.node.fb;

`include "canopen_drive_status_receiver_assert.svh"

  `CDSR_ASSERT(a_req_on_status, out_valid_o && request_error_read_o |-> report_kind_o == RK_STATUS, "error read request outside a status report")
  `CDSR_ASSERT(a_stall_cause, in_stall_o |-> in_valid_q && out_valid_o && out_stall_i, "input stalled without a held report")
  `CDSR_ASSERT_NEVER(a_fb_any, out_valid_o && feedback_flags_o != 4'd0 && !feedback_flags_o[3], "feedback valid without any-valid bit")

endmodule

// ===== src/cdsr_decode.sv =====
// Frame classifier: identifier range, node match, length, SDO command and index checks.
module cdsr_decode (
  input  logic [10:0]          can_id_i,
  input  logic [3:0]           frame_length_i,
  input  logic [63:0]          data_i,
  input  logic [6:0]           left_node_id_i,
  input  logic [6:0]           right_node_id_i,
  output cdsr_pkg::event_t     event_o
);
  import cdsr_pkg::*;

  logic [3:0]  base;
  logic [6:0]  nid;
  logic        hit;
  logic [15:0] index;

  assign base  = can_id_i[10:7];
  assign nid   = can_id_i[6:0];
  assign hit   = (nid == left_node_id_i) || (nid == right_node_id_i);
  assign index = data_i[23:8];

  always_comb begin
    event_o.kind = FK_NONE;
    event_o.side = (nid != left_node_id_i);
    event_o.full = (frame_length_i >= 4'd8);
    case (base)
      BASE_TPDO1: begin
        if (hit && frame_length_i >= 4'd8) event_o.kind = FK_TPDO1;
      end
      BASE_TPDO2: begin
        if (hit && frame_length_i >= 4'd2) event_o.kind = FK_TPDO2;
      end
      BASE_SDO: begin
        if (hit && frame_length_i >= 4'd6 && (data_i[7:0] & SDO_CMD_MASK) == SDO_CMD_UPLOAD
            && data_i[31:24] == 8'h00) begin
          if (index == OBJ_STATUS_WORD) event_o.kind = FK_SW;
          else if (index == OBJ_ERROR_CODE) event_o.kind = FK_ERR;
        end
      end
      BASE_EMCY: begin
        if (hit && nid != 7'd0 && frame_length_i >= 4'd3) event_o.kind = FK_EMCY;
      end
      default: event_o.kind = FK_NONE;
    endcase
  end

endmodule

// ===== src/cdsr_nodes.sv =====
// Per-drive state of both drives and the update for one frame.
module cdsr_nodes (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cdsr_pkg::event_t    event_i,
  input  logic [63:0]         data_i,
  output cdsr_pkg::result_t   result_o
);
  import cdsr_pkg::*;

  node_t node_q [2];
  node_t cur;
  node_t nw;
  logic  prior_fault;
  logic  fault;
  logic  req;
  logic  emit;
  report_kind_e kind;
  logic [15:0] val;
  logic [15:0] code;

  assign cur  = node_q[event_i.side];
  assign val  = data_i[47:32];
  assign code = data_i[15:0];
  assign prior_fault = cur.flags[FL_VALID] && cur.flags[FL_FAULT];
  assign fault = val[3];

  always_comb begin
    nw   = cur;
    emit = 1'b0;
    req  = 1'b0;
    kind = RK_STATUS;
    case (event_i.kind)
      FK_TPDO1: begin
        nw.pos = data_i[31:0];
        nw.vel = data_i[63:32];
        nw.fb  = cur.fb | FB_POS_VEL;
        emit   = 1'b1;
        kind   = RK_FEEDBACK;
      end
      FK_TPDO2: begin
        nw.cur = data_i[15:0];
        nw.fb  = cur.fb | FB_CURRENT;
        if (event_i.full) begin
          nw.vd = data_i[47:16];
          nw.cd = data_i[63:48];
          nw.fb = cur.fb | FB_CURRENT | FB_DEMANDS;
        end
        emit = 1'b1;
        kind = RK_CURRENT;
      end
      FK_SW: begin
        nw.sw = val;
        nw.flags = {1'b1, val[1] & val[2], val[3:0]};
        if (fault) begin
          if (cur.msg == MSG_NONE) nw.msg = MSG_SW_FAULT;
        end else begin
          nw.msg = MSG_NONE;
        end
        if (fault && !prior_fault) begin
          if (!cur.pend) begin
            req     = 1'b1;
            nw.pend = 1'b1;
          end
        end else if (!fault && prior_fault) begin
          nw.pend = 1'b0;
        end
        emit = 1'b1;
      end
      FK_ERR: begin
        nw.pend = 1'b0;
        if (val != cur.err) begin
          nw.err = val;
          emit   = 1'b1;
        end
      end
      FK_EMCY: begin
        nw.flags[FL_VALID] = 1'b1;
        if (code != 16'h0000 && code[15:8] == EMCY_COMM_HI && code != EMCY_COMM_FAULT) begin
          nw.err = code;
        end else if (code != 16'h0000) begin
          nw.err = code;
          nw.flags[FL_FAULT] = 1'b1;
          nw.flags[FL_MOTOR] = 1'b0;
          nw.flags[FL_OPEN]  = 1'b0;
          nw.msg  = MSG_EMCY;
          nw.pend = 1'b1;
        end else begin
          nw.msg = MSG_NONE;
        end
        emit = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) node_q[i] <= '0;
    end else if (en_i && event_i.kind != FK_NONE) begin
      node_q[event_i.side] <= nw;
    end
  end

  assign result_o.emit = emit;
  assign result_o.kind = kind;
  assign result_o.side = event_i.side;
  assign result_o.req  = req;
  assign result_o.node = nw;

endmodule

// ===== tb/testbench.sv =====
// Testbench for the CANopen drive status receiver: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import cdsr_pkg::*;

  localparam logic [10:0] ID_EMCY  = 11'h080;
  localparam logic [10:0] ID_TPDO1 = 11'h180;
  localparam logic [10:0] ID_TPDO2 = 11'h280;
  localparam logic [10:0] ID_SDO   = 11'h580;
  localparam logic [2:0]  ADDR_LEFT  = 3'd0;
  localparam logic [2:0]  ADDR_RIGHT = 3'd4;
  localparam int NO_SIDE = 2;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  kind;
    logic        side;
    logic [15:0] sw;
    logic [15:0] err;
    logic [7:0]  flags;
    logic        req;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [15:0] cur;
    logic [31:0] vd;
    logic [15:0] cd;
    logic [3:0]  fb;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [10:0] can_id_i = '0;
  logic [3:0] frame_length_i = '0;
  logic [7:0] byte0_i = '0, byte1_i = '0, byte2_i = '0, byte3_i = '0;
  logic [7:0] byte4_i = '0, byte5_i = '0, byte6_i = '0, byte7_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [1:0] report_kind_o;
  logic side_o;
  logic [15:0] drive_status_word_o, drive_error_code_o;
  logic [7:0] status_flags_o;
  logic request_error_read_o;
  logic signed [31:0] position_o, velocity_o, velocity_setpoint_o;
  logic signed [15:0] current_o, current_setpoint_o;
  logic [3:0] feedback_flags_o;

  canopen_drive_status_receiver u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [6:0]  left_id = 7'd1, right_id = 7'd2;
  logic [15:0] sw_q[2], err_q[2];
  logic [5:0]  flg_q[2];
  logic [1:0]  msg_q[2];
  logic        pend_q[2];
  logic [31:0] pos_q[2], vel_q[2], vd_q[2];
  logic [15:0] cur_q[2], cd_q[2];
  logic [3:0]  fb_q[2];
  report_t     pending_reports[$];

  int  errors = 0;
  bit  idle_on = 1'b1;
  bit  hold_now = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  apb_busy = 1'b0;

  function automatic int pick_side(logic [6:0] nid);
    if (nid == left_id) return 0;
    if (nid == right_id) return 1;
    return NO_SIDE;
  endfunction

  task automatic push_report(report_kind_e kind, int s, logic req);
    report_t r;
    r.kind = kind; r.side = s[0]; r.sw = sw_q[s]; r.err = err_q[s];
    r.flags = {msg_q[s], flg_q[s]}; r.req = req; r.pos = pos_q[s]; r.vel = vel_q[s];
    r.cur = cur_q[s]; r.vd = vd_q[s]; r.cd = cd_q[s]; r.fb = fb_q[s];
    pending_reports.insert(pending_reports.size(), r);
  endtask

  task automatic apply_status_word(int s, logic [15:0] sw);
    logic prior_fault, fault, req;
    logic [5:0] f;
    prior_fault = flg_q[s][FL_VALID] && flg_q[s][FL_FAULT];
    f = {2'b00, sw[3:0]};
    fault = f[FL_FAULT];
    req = 1'b0;
    if (f[FL_SWITCHED] && f[FL_OPEN]) f[FL_MOTOR] = 1'b1;
    f[FL_VALID] = 1'b1;
    sw_q[s] = sw;
    flg_q[s] = f;
    if (fault) begin
      if (msg_q[s] == MSG_NONE) msg_q[s] = MSG_SW_FAULT;
    end else begin
      msg_q[s] = MSG_NONE;
    end
    if (fault && !prior_fault) begin
      if (!pend_q[s]) begin
        req = 1'b1;
        pend_q[s] = 1'b1;
      end
    end else if (!fault && prior_fault) begin
      pend_q[s] = 1'b0;
    end
    push_report(RK_STATUS, s, req);
  endtask

  task automatic predict_frame(logic [10:0] id, logic [3:0] len, logic [63:0] d);
    int s;
    logic [15:0] code, idx, val;
    if (id >= ID_TPDO1 && id <= ID_TPDO1 + 11'h7F) begin
      s = pick_side(7'(id - ID_TPDO1));
      if (len < 8 || s == NO_SIDE) return;
      pos_q[s] = d[31:0];
      vel_q[s] = d[63:32];
      fb_q[s] |= FB_POS_VEL;
      push_report(RK_FEEDBACK, s, 1'b0);
    end else if (id >= ID_TPDO2 && id <= ID_TPDO2 + 11'h7F) begin
      s = pick_side(7'(id - ID_TPDO2));
      if (len < 2 || s == NO_SIDE) return;
      cur_q[s] = d[15:0];
      fb_q[s] |= FB_CURRENT;
      if (len >= 8) begin
        vd_q[s] = d[47:16];
        cd_q[s] = d[63:48];
        fb_q[s] |= FB_DEMANDS;
      end
      push_report(RK_CURRENT, s, 1'b0);
    end else if (id >= ID_SDO && id <= ID_SDO + 11'h7F) begin
      s = pick_side(7'(id - ID_SDO));
      if (len < 4 || s == NO_SIDE) return;
      if ((d[7:0] & SDO_CMD_MASK) != SDO_CMD_UPLOAD) return;
      idx = d[23:8];
      if (d[31:24] != 8'h00 || len < 6) return;
      val = d[47:32];
      if (idx == OBJ_STATUS_WORD) begin
        apply_status_word(s, val);
      end else if (idx == OBJ_ERROR_CODE) begin
        pend_q[s] = 1'b0;
        if (val != err_q[s]) begin
          err_q[s] = val;
          push_report(RK_STATUS, s, 1'b0);
        end
      end
    end else if (id >= ID_EMCY + 11'h1 && id <= ID_EMCY + 11'h7F) begin
      s = pick_side(7'(id - ID_EMCY));
      if (s == NO_SIDE || len < 3) return;
      code = d[15:0];
      flg_q[s][FL_VALID] = 1'b1;
      if (code != 0 && code[15:8] == EMCY_COMM_HI && code != EMCY_COMM_FAULT) begin
        err_q[s] = code;
      end else if (code != 0) begin
        err_q[s] = code;
        flg_q[s][FL_FAULT] = 1'b1;
        flg_q[s][FL_MOTOR] = 1'b0;
        flg_q[s][FL_OPEN] = 1'b0;
        msg_q[s] = MSG_EMCY;
        pend_q[s] = 1'b1;
      end else begin
        msg_q[s] = MSG_NONE;
      end
      push_report(RK_STATUS, s, 1'b0);
    end
  endtask

  task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [63:0] d);
    if (idle_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    can_id_i <= id;
    frame_length_i <= len;
    {byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i, byte0_i} <= d;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(id, len, d);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_reports.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [6:0] value);
    apb_busy = 1'b1;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_LEFT) left_id = value;
    else right_id = value;
    apb_busy = 1'b0;
  endtask

  task automatic set_nodes(logic [6:0] l, logic [6:0] r);
    end_burst();
    write_reg(ADDR_LEFT, l);
    write_reg(ADDR_RIGHT, r);
  endtask

  function automatic logic [63:0] sdo_data(logic [7:0] cmd, logic [15:0] idx,
                                            logic [7:0] sub, logic [15:0] val);
    return {16'h0000, val, sub, idx, cmd};
  endfunction

  function automatic logic [63:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_frame(ID_TPDO1 + 11'd1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(ID_TPDO1 + 11'd2, 4'd8, 64'h8000_0000_7FFF_FFFF);
    send_frame(ID_TPDO1 + 11'd1, 4'd7, rand_bytes());
    send_frame(ID_TPDO2 + 11'd1, 4'd2, 64'h0000_0000_0000_8000);
    send_frame(ID_TPDO2 + 11'd2, 4'd8, 64'h7FFF_8000_0000_FFFF);
    send_frame(ID_TPDO2 + 11'd1, 4'd1, rand_bytes());
    send_frame(ID_TPDO2 + 11'd1, 4'd15, rand_bytes());
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h4B, OBJ_STATUS_WORD, 8'h00, 16'h0008));
    send_frame(ID_SDO + 11'd1, 4'd6, sdo_data(8'h4B, OBJ_STATUS_WORD, 8'h00, 16'hFFFF));
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h4B, OBJ_ERROR_CODE, 8'h00, 16'h2310));
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h4B, OBJ_ERROR_CODE, 8'h00, 16'h2310));
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h4F, OBJ_STATUS_WORD, 8'h00, 16'h0027));
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h80, OBJ_STATUS_WORD, 8'h00, 16'h0008));
    send_frame(ID_SDO + 11'd1, 4'd8, sdo_data(8'h4B, 16'h6061, 8'h00, 16'h0008));
    send_frame(ID_SDO + 11'd2, 4'd8, sdo_data(8'h4B, OBJ_STATUS_WORD, 8'h01, 16'h0008));
    send_frame(ID_SDO + 11'd2, 4'd5, sdo_data(8'h4B, OBJ_STATUS_WORD, 8'h00, 16'h0008));
    send_frame(ID_SDO + 11'd2, 4'd3, sdo_data(8'h4B, OBJ_STATUS_WORD, 8'h00, 16'h0008));
    send_frame(ID_EMCY + 11'd2, 4'd8, 64'h0000_0000_0000_8110);
    send_frame(ID_EMCY + 11'd2, 4'd3, 64'h0000_0000_0000_8130);
    send_frame(ID_EMCY + 11'd2, 4'd8, 64'h0000_0000_0000_0000);
    send_frame(ID_EMCY + 11'd1, 4'd2, 64'h0000_0000_0000_FF00);
    send_frame(ID_EMCY + 11'd1, 4'd0, 64'h0000_0000_0000_5530);
    send_frame(ID_EMCY, 4'd8, 64'h0000_0000_0000_8130);
    send_frame(11'h7FF, 4'd8, rand_bytes());
    send_frame(ID_TPDO1 + 11'd3, 4'd8, rand_bytes());
  endtask

  task automatic test_node_config();
    set_nodes(7'd5, 7'd5);
    send_frame(ID_TPDO1 + 11'd5, 4'd8, rand_bytes());
    send_frame(ID_EMCY + 11'd5, 4'd8, 64'h0000_0000_0000_3210);
    set_nodes(7'd0, 7'd127);
    send_frame(ID_TPDO2, 4'd8, rand_bytes());
    send_frame(ID_TPDO2 + 11'd127, 4'd8, rand_bytes());
    send_frame(ID_SDO + 11'd127, 4'd6, sdo_data(8'h43, OBJ_STATUS_WORD, 8'h00, 16'h000F));
    send_frame(ID_EMCY + 11'd127, 4'd4, 64'h0000_0000_0000_8130);
  endtask

  task automatic send_random_frame();
    logic [6:0] nid;
    logic [63:0] d;
    logic [15:0] code;
    logic [3:0] len;
    int pick;
    pick = $urandom_range(99);
    nid = (pick < 45) ? left_id : (pick < 90) ? right_id : 7'($urandom);
    d = rand_bytes();
    len = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd8;
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(3))
          0: code = 16'h0000;
          1: code = {EMCY_COMM_HI, 8'($urandom)};
          2: code = EMCY_COMM_FAULT;
          default: code = 16'($urandom);
        endcase
        send_frame(ID_EMCY + 11'(nid), len, {d[63:16], code});
      end
      2, 3: send_frame(ID_TPDO1 + 11'(nid), len, d);
      4, 5: send_frame(ID_TPDO2 + 11'(nid), len, d);
      6, 7, 8: begin
        if ($urandom_range(1)) begin
          send_frame(ID_SDO + 11'(nid), len,
                     sdo_data(SDO_CMD_UPLOAD | 8'($urandom_range(31)), OBJ_STATUS_WORD,
                              8'h00, {d[15:4], 1'($urandom_range(2) == 0), d[2:0]}));
        end else begin
          send_frame(ID_SDO + 11'(nid), len,
                     sdo_data(SDO_CMD_UPLOAD | 8'($urandom_range(31)), OBJ_ERROR_CODE,
                              8'h00, 16'($urandom_range(3))));
        end
      end
      default: send_frame(11'($urandom), 4'($urandom), d);
    endcase
  endtask

  task automatic test_random(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_now = 1'b1;
      send_random_frame();
    end
  endtask

  task automatic test_random_sweep();
    set_nodes(7'd1, 7'd2);
    test_random(250, 1'b1);
    set_nodes(7'd127, 7'd0);
    idle_on = 1'b0;
    test_random(200, 1'b0);
    idle_on = 1'b1;
    set_nodes(7'd9, 7'd9);
    test_random(100, 1'b0);
    set_nodes(7'($urandom), 7'($urandom));
    test_random(300, 1'b0);
    end_burst();
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    report_t e;
    bit moved;
    moved = apb_busy || (in_valid_i && !in_stall_o);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: kind %0d side %0d", $time, report_kind_o, side_o);
        errors++;
      end else begin
        e = pending_reports.pop_front();
        check_field("report_kind", 32'(e.kind), 32'(report_kind_o));
        check_field("side", 32'(e.side), 32'(side_o));
        check_field("drive_status_word", 32'(e.sw), 32'(drive_status_word_o));
        check_field("drive_error_code", 32'(e.err), 32'(drive_error_code_o));
        check_field("status_flags", 32'(e.flags), 32'(status_flags_o));
        check_field("request_error_read", 32'(e.req), 32'(request_error_read_o));
        check_field("position", e.pos, position_o);
        check_field("velocity", e.vel, velocity_o);
        check_field("current", {16'h0000, e.cur}, {16'h0000, current_o});
        check_field("velocity_setpoint", e.vd, velocity_setpoint_o);
        check_field("current_setpoint", {16'h0000, e.cd}, {16'h0000, current_setpoint_o});
        check_field("feedback_flags", 32'(e.fb), 32'(feedback_flags_o));
      end
    end
    if (hold_now) begin
      hold_now = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || (idle_on && $urandom_range(99) < 35);
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < 2; s++) begin
      sw_q[s] = '0; err_q[s] = '0; flg_q[s] = '0; msg_q[s] = MSG_NONE; pend_q[s] = 1'b0;
      pos_q[s] = '0; vel_q[s] = '0; cur_q[s] = '0; vd_q[s] = '0; cd_q[s] = '0; fb_q[s] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_node_config();
    test_random_sweep();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/cdsr_pkg.sv
src/cdsr_decode.sv
src/cdsr_nodes.sv
src/canopen_drive_status_receiver.sv
tb/testbench.sv
